@@ sv/asc_pkg.sv @@
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and helpers for the static box contact scan.
// ----------------------------------------------------------------------------
package asc_pkg;

    // Number of static table slots
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths fixed by the interface
    localparam int POS_W  = 24;
    localparam int HALF_W = 22;
    localparam int TAG_W  = 8;
    localparam int SLOT_W = 4;
    localparam int NRM_W  = 2;
    localparam int FLG_W  = 4;

    // Internal arithmetic widths
    localparam int DIFF_W = POS_W + 1;   // centre difference
    localparam int PEN_W  = POS_W + 2;   // penetration depth, signed
    localparam int SUM_W  = HALF_W + 1;  // sum of two half sizes

    // Request action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Side flag bit positions
    localparam int FLG_LEFT   = 0;
    localparam int FLG_RIGHT  = 1;
    localparam int FLG_TOP    = 2;
    localparam int FLG_BOTTOM = 3;

    // Normal codes
    localparam logic [NRM_W-1:0] NRM_POS  = 2'b01;
    localparam logic [NRM_W-1:0] NRM_NEG  = 2'b11;
    localparam logic [NRM_W-1:0] NRM_ZERO = 2'b00;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // write table slot and send acknowledge
        logic query;   // latch query box, restart scan
        logic issue;   // read current slot into the test stage
        logic flush;   // empty the test stage
        logic sum;     // send the summary result
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic scan_last;  // scan index is on the final slot
    } t_dp_sts;

    // Saturate a widened coordinate to the signed output range
    function automatic logic [POS_W-1:0] sat_pos(input logic signed [PEN_W-1:0] v);
        logic signed [PEN_W-1:0] hi;
        logic signed [PEN_W-1:0] lo;
        hi = PEN_W'(signed'({1'b0, {(POS_W-1){1'b1}}}));
        lo = -hi - PEN_W'(1);
        if (v > hi) begin
            sat_pos = {1'b0, {(POS_W-1){1'b1}}};
        end else if (v < lo) begin
            sat_pos = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

endpackage

@@ sv/asc_ctrl.sv @@
// ----------------------------------------------------------------------------
// asc_ctrl
// Sequencer for load requests, the slot scan, pipeline flush and summary.
// ----------------------------------------------------------------------------
module asc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_action,
    output logic              o_stall,
    input  asc_pkg::t_dp_sts  i_sts,
    output asc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_SUM   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A request is only taken when the output register can hold its result
    assign o_stall = !((r_state == S_IDLE) && i_sts.out_free);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_sts.out_free) begin
                    if (i_action == asc_pkg::ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.query = 1'b1;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.out_free) begin
                    o_cmd.issue = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_SUM;
                end
            end
            S_SUM: begin
                if (i_sts.out_free) begin
                    o_cmd.sum = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_issue_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_state == S_SCAN) && i_sts.out_free)
        else $error("scan issue outside scan or while output blocked");

    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load || o_cmd.query) |-> !o_stall && i_valid)
        else $error("request used without handshake");

    a_sum_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sum |-> $past(r_state) == S_FLUSH || $past(r_state) == S_SUM)
        else $error("summary without pipeline flush");

endmodule

@@ sv/asc_dp.sv @@
// ----------------------------------------------------------------------------
// asc_dp
// Box table, query registers, two-stage overlap test and output register.
// ----------------------------------------------------------------------------
module asc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  asc_pkg::t_dp_cmd                     i_cmd,
    output asc_pkg::t_dp_sts                     o_sts,
    input  logic [asc_pkg::SLOT_W-1:0]           i_entry_index,
    input  logic                                 i_entry_active,
    input  logic [asc_pkg::TAG_W-1:0]            i_body_id,
    input  logic signed [asc_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [asc_pkg::POS_W-1:0]     i_pos_y,
    input  logic [asc_pkg::HALF_W-1:0]           i_half_x,
    input  logic [asc_pkg::HALF_W-1:0]           i_half_y,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [asc_pkg::TAG_W-1:0]            o_query_tag,
    output logic [asc_pkg::SLOT_W-1:0]           o_hit_entry,
    output logic signed [asc_pkg::POS_W-1:0]     o_delta_x,
    output logic signed [asc_pkg::POS_W-1:0]     o_delta_y,
    output logic signed [asc_pkg::NRM_W-1:0]     o_normal_x,
    output logic signed [asc_pkg::NRM_W-1:0]     o_normal_y,
    output logic signed [asc_pkg::POS_W-1:0]     o_contact_x,
    output logic signed [asc_pkg::POS_W-1:0]     o_contact_y,
    output logic [asc_pkg::FLG_W-1:0]            o_side_flags,
    output logic                                 o_last
);

    localparam int N   = asc_pkg::ENTRIES;
    localparam int IW  = asc_pkg::IDX_W;
    localparam int PW  = asc_pkg::POS_W;
    localparam int HW  = asc_pkg::HALF_W;
    localparam int DW  = asc_pkg::DIFF_W;
    localparam int EW  = asc_pkg::PEN_W;
    localparam int SW  = asc_pkg::SUM_W;
    localparam int FW  = asc_pkg::FLG_W;

    // Static box table
    logic signed [PW-1:0] r_tab_cx [N];
    logic signed [PW-1:0] r_tab_cy [N];
    logic [HW-1:0]        r_tab_hx [N];
    logic [HW-1:0]        r_tab_hy [N];
    logic [N-1:0]         r_tab_act;

    // Query box
    logic signed [PW-1:0]         r_qx;
    logic signed [PW-1:0]         r_qy;
    logic [HW-1:0]                r_qhx;
    logic [HW-1:0]                r_qhy;
    logic [asc_pkg::TAG_W-1:0]    r_tag;
    logic [IW-1:0]                r_idx;
    logic [FW-1:0]                r_flags;

    // Test stage
    logic                 r_a_vld;
    logic [IW-1:0]        r_a_idx;
    logic signed [EW-1:0] r_a_px;
    logic signed [EW-1:0] r_a_py;
    logic                 r_a_xneg;
    logic                 r_a_yneg;
    logic signed [PW-1:0] r_a_ex;
    logic signed [PW-1:0] r_a_ey;
    logic [HW-1:0]        r_a_ehx;
    logic [HW-1:0]        r_a_ehy;

    // Output register
    logic r_out_vld;

    logic                 out_free;
    logic                 slot_ok;
    logic [IW-1:0]        w_addr;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic [SW-1:0]        hsx;
    logic [SW-1:0]        hsy;
    logic signed [EW-1:0] n_px;
    logic signed [EW-1:0] n_py;

    logic                 hit;
    logic                 xsel;
    logic signed [EW-1:0] cx_wide;
    logic signed [EW-1:0] cy_wide;
    logic [PW-1:0]        pen_x;
    logic [PW-1:0]        pen_y;

    assign out_free        = !r_out_vld || !i_stall;
    assign o_sts.out_free  = out_free;
    assign o_sts.scan_last = (r_idx == IW'(N - 1));
    assign o_valid         = r_out_vld;

    assign slot_ok = (8'(i_entry_index) < 8'(N));
    assign w_addr  = IW'(i_entry_index);

    // Overlap depths for the slot under the scan index
    assign dx   = DW'(r_qx) - DW'(r_tab_cx[r_idx]);
    assign dy   = DW'(r_qy) - DW'(r_tab_cy[r_idx]);
    assign adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign hsx  = SW'(r_qhx) + SW'(r_tab_hx[r_idx]);
    assign hsy  = SW'(r_qhy) + SW'(r_tab_hy[r_idx]);
    assign n_px = signed'(EW'(hsx)) - signed'(EW'(adx));
    assign n_py = signed'(EW'(hsy)) - signed'(EW'(ady));

    // Resolve on the axis of smaller penetration; a tie goes to y
    assign hit  = r_a_vld && (r_a_px > EW'(0)) && (r_a_py > EW'(0));
    assign xsel = (r_a_px < r_a_py);
    assign pen_x = r_a_px[PW-1:0];
    assign pen_y = r_a_py[PW-1:0];
    assign cx_wide = r_a_xneg ? (EW'(r_a_ex) - signed'(EW'(r_a_ehx)))
                              : (EW'(r_a_ex) + signed'(EW'(r_a_ehx)));
    assign cy_wide = r_a_yneg ? (EW'(r_a_ey) - signed'(EW'(r_a_ehy)))
                              : (EW'(r_a_ey) + signed'(EW'(r_a_ehy)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && slot_ok) begin
            r_tab_cx[w_addr] <= i_pos_x;
            r_tab_cy[w_addr] <= i_pos_y;
            r_tab_hx[w_addr] <= i_half_x;
            r_tab_hy[w_addr] <= i_half_y;
        end
        if (i_cmd.query) begin
            r_qx  <= i_pos_x;
            r_qy  <= i_pos_y;
            r_qhx <= i_half_x;
            r_qhy <= i_half_y;
            r_tag <= i_body_id;
        end
        if (i_cmd.issue) begin
            r_a_idx  <= r_idx;
            r_a_px   <= n_px;
            r_a_py   <= n_py;
            r_a_xneg <= dx[DW-1];
            r_a_yneg <= dy[DW-1];
            r_a_ex   <= r_tab_cx[r_idx];
            r_a_ey   <= r_tab_cy[r_idx];
            r_a_ehx  <= r_tab_hx[r_idx];
            r_a_ehy  <= r_tab_hy[r_idx];
        end
        // Output payload
        if (i_cmd.load) begin
            o_query_tag  <= i_body_id;
            o_hit_entry  <= '0;
            o_delta_x    <= '0;
            o_delta_y    <= '0;
            o_normal_x   <= asc_pkg::NRM_ZERO;
            o_normal_y   <= asc_pkg::NRM_ZERO;
            o_contact_x  <= '0;
            o_contact_y  <= '0;
            o_side_flags <= '0;
            o_last       <= 1'b1;
        end else if (i_cmd.sum) begin
            o_query_tag  <= r_tag;
            o_hit_entry  <= '0;
            o_delta_x    <= '0;
            o_delta_y    <= '0;
            o_normal_x   <= asc_pkg::NRM_ZERO;
            o_normal_y   <= asc_pkg::NRM_ZERO;
            o_contact_x  <= '0;
            o_contact_y  <= '0;
            o_side_flags <= r_flags;
            o_last       <= 1'b1;
        end else if ((i_cmd.issue || i_cmd.flush) && hit) begin
            o_query_tag  <= r_tag;
            o_hit_entry  <= asc_pkg::SLOT_W'(r_a_idx);
            o_side_flags <= '0;
            o_last       <= 1'b0;
            if (xsel) begin
                o_delta_x   <= r_a_xneg ? PW'(-pen_x) : pen_x;
                o_delta_y   <= '0;
                o_normal_x  <= r_a_xneg ? asc_pkg::NRM_NEG : asc_pkg::NRM_POS;
                o_normal_y  <= asc_pkg::NRM_ZERO;
                o_contact_x <= asc_pkg::sat_pos(cx_wide);
                o_contact_y <= r_qy;
            end else begin
                o_delta_x   <= '0;
                o_delta_y   <= r_a_yneg ? PW'(-pen_y) : pen_y;
                o_normal_x  <= asc_pkg::NRM_ZERO;
                o_normal_y  <= r_a_yneg ? asc_pkg::NRM_NEG : asc_pkg::NRM_POS;
                o_contact_x <= r_qx;
                o_contact_y <= asc_pkg::sat_pos(cy_wide);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_act <= '0;
            r_idx     <= '0;
            r_flags   <= '0;
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load && slot_ok) begin
                r_tab_act[w_addr] <= i_entry_active;
            end
            if (i_cmd.query) begin
                r_idx   <= '0;
                r_flags <= '0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + IW'(1);
            end
            if ((i_cmd.issue || i_cmd.flush) && hit) begin
                if (xsel) begin
                    if (r_a_xneg) begin
                        r_flags[asc_pkg::FLG_RIGHT] <= 1'b1;
                    end else begin
                        r_flags[asc_pkg::FLG_LEFT] <= 1'b1;
                    end
                end else begin
                    if (r_a_yneg) begin
                        r_flags[asc_pkg::FLG_TOP] <= 1'b1;
                    end else begin
                        r_flags[asc_pkg::FLG_BOTTOM] <= 1'b1;
                    end
                end
            end
            if (i_cmd.issue) begin
                r_a_vld <= r_tab_act[r_idx];
            end else if (i_cmd.flush || i_cmd.query) begin
                r_a_vld <= 1'b0;
            end
            if (i_cmd.load || i_cmd.sum || ((i_cmd.issue || i_cmd.flush) && hit)) begin
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> (o_hit_entry == '0) && (o_delta_x == '0)
                              && (o_delta_y == '0) && (o_normal_x == asc_pkg::NRM_ZERO)
                              && (o_normal_y == asc_pkg::NRM_ZERO))
        else $error("summary carries hit data");

    a_hit_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> ((o_normal_x != asc_pkg::NRM_ZERO)
                               != (o_normal_y != asc_pkg::NRM_ZERO))
                               && (o_side_flags == '0))
        else $error("hit result without a single contact axis");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> r_out_vld)
        else $error("pending result dropped while stalled");

endmodule

@@ sv/aabb_static_contact_scan.sv @@
// ----------------------------------------------------------------------------
// aabb_static_contact_scan
// Static box table with per-query overlap scan and contact resolution.
// ----------------------------------------------------------------------------
// A load request writes one table slot and returns a single acknowledge with
// o_last set. A query request scans every slot in order, one overlap test per
// cycle while the output register is free, through a two-stage test
// pipeline, emits one result per overlapping active slot and closes with a
// summary carrying the side flags and o_last. Every slot is read through the
// single shared test stage. Requests are taken only between queries, and only
// while the output register can accept a result.
module aabb_static_contact_scan (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_action,
    input  logic [asc_pkg::SLOT_W-1:0]           i_entry_index,
    input  logic                                 i_entry_active,
    input  logic [asc_pkg::TAG_W-1:0]            i_body_id,
    input  logic signed [asc_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [asc_pkg::POS_W-1:0]     i_pos_y,
    input  logic [asc_pkg::HALF_W-1:0]           i_half_x,
    input  logic [asc_pkg::HALF_W-1:0]           i_half_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [asc_pkg::TAG_W-1:0]            o_query_tag,
    output logic [asc_pkg::SLOT_W-1:0]           o_hit_entry,
    output logic signed [asc_pkg::POS_W-1:0]     o_delta_x,
    output logic signed [asc_pkg::POS_W-1:0]     o_delta_y,
    output logic signed [asc_pkg::NRM_W-1:0]     o_normal_x,
    output logic signed [asc_pkg::NRM_W-1:0]     o_normal_y,
    output logic signed [asc_pkg::POS_W-1:0]     o_contact_x,
    output logic signed [asc_pkg::POS_W-1:0]     o_contact_y,
    output logic [asc_pkg::FLG_W-1:0]            o_side_flags,
    output logic                                 o_last
);

    asc_pkg::t_dp_cmd cmd;
    asc_pkg::t_dp_sts sts;

    asc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    asc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_entry_index  (i_entry_index),
        .i_entry_active (i_entry_active),
        .i_body_id      (i_body_id),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_half_x       (i_half_x),
        .i_half_y       (i_half_y),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_query_tag    (o_query_tag),
        .o_hit_entry    (o_hit_entry),
        .o_delta_x      (o_delta_x),
        .o_delta_y      (o_delta_y),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_contact_x    (o_contact_x),
        .o_contact_y    (o_contact_y),
        .o_side_flags   (o_side_flags),
        .o_last         (o_last)
    );

endmodule

@@ test/tb_aabb_static_contact_scan.sv @@
// ----------------------------------------------------------------------------
// tb_aabb_static_contact_scan
// Self-checking bench for the static box contact scan.
// ----------------------------------------------------------------------------
// A table of directed requests covers the extremes, each contact side, the
// tie and zero-distance rules and contact saturation. Random requests follow,
// mostly clustered loads and queries so that scans find several hits. Each
// request is run through a local copy of the box table, and every result is
// compared in order with its prediction or a typed row's given result.
// ----------------------------------------------------------------------------
module tb_aabb_static_contact_scan;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_N      = 22;
    localparam int RAND_N     = 328;
    localparam int HOLD_CYC   = 300;
    localparam int HOLD_AT    = 60;
    localparam int PAUSE_AT   = 200;
    localparam int DRAIN_CYC  = 40;
    localparam longint POS_HI = 64'sd8388607;
    localparam longint POS_LO = -64'sd8388608;

    typedef struct packed {
        logic                              typed;
        logic [asc_pkg::FLG_W-1:0]         tflags;
        logic                              act;
        logic [asc_pkg::SLOT_W-1:0]        idx;
        logic                              on;
        logic [asc_pkg::TAG_W-1:0]         tag;
        logic signed [asc_pkg::POS_W-1:0]  x;
        logic signed [asc_pkg::POS_W-1:0]  y;
        logic [asc_pkg::HALF_W-1:0]        hx;
        logic [asc_pkg::HALF_W-1:0]        hy;
    } t_req;

    typedef struct packed {
        logic [asc_pkg::TAG_W-1:0]         tag;
        logic [asc_pkg::SLOT_W-1:0]        entry;
        logic signed [asc_pkg::POS_W-1:0]  dx;
        logic signed [asc_pkg::POS_W-1:0]  dy;
        logic signed [asc_pkg::NRM_W-1:0]  nx;
        logic signed [asc_pkg::NRM_W-1:0]  ny;
        logic signed [asc_pkg::POS_W-1:0]  cx;
        logic signed [asc_pkg::POS_W-1:0]  cy;
        logic [asc_pkg::FLG_W-1:0]         flags;
        logic                              last;
    } t_contact;

    // typed rows carry a single closing result: ack or summary with no hits
    localparam t_req DIR_ROWS [DIR_N] = '{
        '{1, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h00, 0, 0, 8, 8},
        '{1, 0, asc_pkg::ACT_LOAD,  0,  1, 8'hFF, 0, 0, 16, 16},
        '{1, 0, asc_pkg::ACT_LOAD,  15, 1, 8'h15, 8388607, -8388608, 4194303, 4194303},
        '{1, 0, asc_pkg::ACT_LOAD,  14, 1, 8'h14, 0, -8388600, 4194303, 4194303},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h01, 0, 0, 8, 8},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h02, -20, 0, 8, 32},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h03, 20, 2, 8, 32},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h04, 0, -20, 32, 8},
        '{1, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h05, 32, 0, 16, 16},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h06, 8388607, -8388608, 16, 1000},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h07, 0, -8388608, 1000, 16},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h08, 8388607, -8388608, 4194303, 4194303},
        '{1, 0, asc_pkg::ACT_LOAD,  2,  1, 8'h20, 20, 0, 16, 40},
        '{1, 0, asc_pkg::ACT_LOAD,  3,  1, 8'h21, -20, 0, 16, 40},
        '{1, 0, asc_pkg::ACT_LOAD,  4,  1, 8'h22, 0, 20, 40, 16},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h09, 0, 0, 8, 8},
        '{1, 0, asc_pkg::ACT_LOAD,  0,  0, 8'h30, 0, 0, 16, 16},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h0A, 0, 0, 8, 8},
        '{1, 0, asc_pkg::ACT_LOAD,  5,  1, 8'h31, -1000, -1000, 0, 0},
        '{0, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h0B, -1000, -1000, 1, 1},
        '{1, 0, asc_pkg::ACT_QUERY, 0,  0, 8'h0C, -1000, -1000, 0, 0},
        '{1, 0, asc_pkg::ACT_LOAD,  15, 0, 8'hEE, 0, 0, 0, 0}
    };

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic                              i_action;
    logic [asc_pkg::SLOT_W-1:0]        i_entry_index;
    logic                              i_entry_active;
    logic [asc_pkg::TAG_W-1:0]         i_body_id;
    logic signed [asc_pkg::POS_W-1:0]  i_pos_x;
    logic signed [asc_pkg::POS_W-1:0]  i_pos_y;
    logic [asc_pkg::HALF_W-1:0]        i_half_x;
    logic [asc_pkg::HALF_W-1:0]        i_half_y;
    logic                              o_valid;
    logic                              i_stall;
    logic [asc_pkg::TAG_W-1:0]         o_query_tag;
    logic [asc_pkg::SLOT_W-1:0]        o_hit_entry;
    logic signed [asc_pkg::POS_W-1:0]  o_delta_x;
    logic signed [asc_pkg::POS_W-1:0]  o_delta_y;
    logic signed [asc_pkg::NRM_W-1:0]  o_normal_x;
    logic signed [asc_pkg::NRM_W-1:0]  o_normal_y;
    logic signed [asc_pkg::POS_W-1:0]  o_contact_x;
    logic signed [asc_pkg::POS_W-1:0]  o_contact_y;
    logic [asc_pkg::FLG_W-1:0]         o_side_flags;
    logic                              o_last;

    // shadow of the static box table
    logic signed [asc_pkg::POS_W-1:0]  box_cx [asc_pkg::ENTRIES];
    logic signed [asc_pkg::POS_W-1:0]  box_cy [asc_pkg::ENTRIES];
    logic [asc_pkg::HALF_W-1:0]        box_hx [asc_pkg::ENTRIES];
    logic [asc_pkg::HALF_W-1:0]        box_hy [asc_pkg::ENTRIES];
    logic                              box_on [asc_pkg::ENTRIES];

    t_contact   exp_contacts [$];
    t_contact   scan_out [$];
    int         miss_cnt  = 0;
    int         taken_cnt = 0;
    int         idle_mode = 0;
    logic       row_typed = 1'b0;
    logic [asc_pkg::FLG_W-1:0] row_flags = '0;

    aabb_static_contact_scan DUT (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #8ms;
        $display("aabb_static_contact_scan test failed");
        $finish;
    end

    function automatic logic signed [asc_pkg::POS_W-1:0] clip24(input longint v);
        if (v > POS_HI) return asc_pkg::POS_W'(POS_HI);
        if (v < POS_LO) return asc_pkg::POS_W'(POS_LO);
        return v[asc_pkg::POS_W-1:0];
    endfunction

    // Applies one request to the shadow table and leaves its results in scan_out
    function automatic void resolve_request(input logic act,
                                            input logic [asc_pkg::SLOT_W-1:0] idx,
                                            input logic on,
                                            input logic [asc_pkg::TAG_W-1:0] tag,
                                            input logic signed [asc_pkg::POS_W-1:0] qx,
                                            input logic signed [asc_pkg::POS_W-1:0] qy,
                                            input logic [asc_pkg::HALF_W-1:0] qhx,
                                            input logic [asc_pkg::HALF_W-1:0] qhy);
        t_contact                   r;
        logic [asc_pkg::FLG_W-1:0]  sides;
        longint                     ddx, ddy, pen_x, pen_y, sgn;
        scan_out.delete();
        r = '0;
        r.tag  = tag;
        r.last = 1'b1;
        if (act == asc_pkg::ACT_LOAD) begin
            if (int'(idx) < asc_pkg::ENTRIES) begin
                box_cx[idx] = qx;
                box_cy[idx] = qy;
                box_hx[idx] = qhx;
                box_hy[idx] = qhy;
                box_on[idx] = on;
            end
            scan_out.push_back(r);
            return;
        end
        sides = '0;
        for (int i = 0; i < asc_pkg::ENTRIES; i++) begin
            if (!box_on[i]) continue;
            ddx   = longint'(qx) - longint'(box_cx[i]);
            pen_x = longint'(qhx) + longint'(box_hx[i]) - ((ddx < 0) ? -ddx : ddx);
            if (pen_x <= 0) continue;
            ddy   = longint'(qy) - longint'(box_cy[i]);
            pen_y = longint'(qhy) + longint'(box_hy[i]) - ((ddy < 0) ? -ddy : ddy);
            if (pen_y <= 0) continue;
            r = '0;
            r.tag   = tag;
            r.entry = asc_pkg::SLOT_W'(i);
            // smaller overlap wins, a tie goes to y; zero distance counts as +1
            if (pen_x < pen_y) begin
                sgn  = (ddx < 0) ? -1 : 1;
                r.dx = asc_pkg::POS_W'(pen_x * sgn);
                r.nx = asc_pkg::NRM_W'(sgn);
                r.cx = clip24(longint'(box_cx[i]) + longint'(box_hx[i]) * sgn);
                r.cy = qy;
                sides[(sgn > 0) ? asc_pkg::FLG_LEFT : asc_pkg::FLG_RIGHT] = 1'b1;
            end else begin
                sgn  = (ddy < 0) ? -1 : 1;
                r.dy = asc_pkg::POS_W'(pen_y * sgn);
                r.ny = asc_pkg::NRM_W'(sgn);
                r.cx = qx;
                r.cy = clip24(longint'(box_cy[i]) + longint'(box_hy[i]) * sgn);
                sides[(sgn < 0) ? asc_pkg::FLG_TOP : asc_pkg::FLG_BOTTOM] = 1'b1;
            end
            scan_out.push_back(r);
        end
        r = '0;
        r.tag   = tag;
        r.flags = sides;
        r.last  = 1'b1;
        scan_out.push_back(r);
    endfunction

    // Checks results and predicts each accepted request, in that order
    always @(posedge i_clk) begin : mon
        t_contact got, want, typed_res;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_query_tag, o_hit_entry, o_delta_x, o_delta_y, o_normal_x,
                        o_normal_y, o_contact_x, o_contact_y, o_side_flags, o_last};
                if (exp_contacts.size() == 0) begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display("unexpected result: tag %0d entry %0d last %b",
                                 got.tag, got.entry, got.last);
                end else begin
                    want = exp_contacts.pop_front();
                    if (got !== want) begin
                        miss_cnt++;
                        if (miss_cnt <= 10) begin
                            $display({"exp: tag %0d ent %0d d %0d,%0d n %0d,%0d",
                                      " c %0d,%0d f %h l %b"},
                                     want.tag, want.entry, want.dx, want.dy, want.nx,
                                     want.ny, want.cx, want.cy, want.flags, want.last);
                            $display({"got: tag %0d ent %0d d %0d,%0d n %0d,%0d",
                                      " c %0d,%0d f %h l %b"},
                                     got.tag, got.entry, got.dx, got.dy, got.nx,
                                     got.ny, got.cx, got.cy, got.flags, got.last);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                resolve_request(i_action, i_entry_index, i_entry_active, i_body_id,
                                i_pos_x, i_pos_y, i_half_x, i_half_y);
                if (row_typed) begin
                    typed_res = '0;
                    typed_res.tag   = i_body_id;
                    typed_res.flags = row_flags;
                    typed_res.last  = 1'b1;
                    exp_contacts.push_back(typed_res);
                end else begin
                    foreach (scan_out[k]) exp_contacts.push_back(scan_out[k]);
                end
                taken_cnt++;
            end
        end
    end

    // Output side: random stall, plus one long hold-off to back the block up
    initial begin : rx
        int hold_left;
        bit held;
        int pct;
        hold_left = 0;
        held      = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            pct = (idle_mode == 0) ? 62 : (idle_mode == 1) ? 37 : 0;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!held && taken_cnt >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYC - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    task automatic offer(input t_req rq);
        int pct;
        pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 62 : 0;
        while ($urandom_range(99) < pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_action       <= rq.act;
        i_entry_index  <= rq.idx;
        i_entry_active <= rq.on;
        i_body_id      <= rq.tag;
        i_pos_x        <= rq.x;
        i_pos_y        <= rq.y;
        i_half_x       <= rq.hx;
        i_half_y       <= rq.hy;
        i_valid        <= 1'b1;
        row_typed = rq.typed;
        row_flags = rq.tflags;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stim
        t_req rq;
        int   base_x, base_y;
        bit   wide;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = asc_pkg::ACT_LOAD;
        i_entry_index  = '0;
        i_entry_active = 1'b0;
        i_body_id      = '0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_half_x       = '0;
        i_half_y       = '0;
        base_x         = 0;
        base_y         = 0;
        for (int i = 0; i < asc_pkg::ENTRIES; i++) box_on[i] = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < DIR_N; n++) offer(DIR_ROWS[n]);

        for (int n = 0; n < RAND_N; n++) begin
            idle_mode = (n < 110) ? 0 : (n < 220) ? 1 : 2;
            if (n == PAUSE_AT) begin
                i_valid <= 1'b0;
                while (exp_contacts.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            // move the cluster now and then, sometimes right up to the range edge
            if (n % 70 == 0) begin
                base_x = int'($urandom_range(16773000)) - 8386500;
                base_y = int'($urandom_range(16773000)) - 8386500;
            end
            wide      = ($urandom_range(99) < 10);
            rq        = '0;
            rq.act    = ($urandom_range(99) < 35) ? asc_pkg::ACT_LOAD : asc_pkg::ACT_QUERY;
            rq.idx    = asc_pkg::SLOT_W'($urandom_range(asc_pkg::ENTRIES - 1));
            rq.on     = ($urandom_range(99) < 85);
            rq.tag    = asc_pkg::TAG_W'($urandom);
            if (wide) begin
                rq.x  = asc_pkg::POS_W'($urandom);
                rq.y  = asc_pkg::POS_W'($urandom);
                rq.hx = asc_pkg::HALF_W'($urandom);
                rq.hy = asc_pkg::HALF_W'($urandom);
            end else begin
                rq.x  = asc_pkg::POS_W'(base_x + int'($urandom_range(4000)) - 2000);
                rq.y  = asc_pkg::POS_W'(base_y + int'($urandom_range(4000)) - 2000);
                rq.hx = asc_pkg::HALF_W'($urandom_range(800));
                rq.hy = asc_pkg::HALF_W'($urandom_range(800));
            end
            offer(rq);
        end
        i_valid <= 1'b0;

        while (exp_contacts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (miss_cnt == 0 && exp_contacts.size() == 0)
            $display("aabb_static_contact_scan test passed");
        else
            $display("aabb_static_contact_scan test failed");
        $finish;
    end

endmodule
